// ===== rtl/edge_event_timestamp_fifo_macros.svh =====
// Assertion macros shared by the edge event FIFO RTL.
// Expects signals clk and rst in the scope of each use.
`ifndef EDGE_EVENT_TIMESTAMP_FIFO_MACROS_SVH
`define EDGE_EVENT_TIMESTAMP_FIFO_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EETF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge_event_timestamp_fifo: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EETF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge_event_timestamp_fifo: next-cycle check failed");

`endif

// ===== rtl/eetf_pkg.sv =====
// Package for the edge event FIFO: ring sizing, opcodes, event kinds,
// command/result/entry structs and the ring pointer helper. No dependencies.
package eetf_pkg;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_EDGE     = 2'd0,
    OP_POP      = 2'd1,
    OP_POP_LOST = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LOW  = 2'd1;
  localparam logic [1:0] KIND_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        pin_level;
    logic [63:0] edge_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  popped_kind;
    logic [31:0] popped_sequence;
    logic [63:0] popped_time;
    logic        popped_dropped_before;
    logic [5:0]  queued_count;
    logic        level_now;
    logic [31:0] latest_sequence;
    logic [63:0] latest_time;
    logic [63:0] total_count;
    logic [63:0] delivered_count;
    logic [63:0] dropped_count;
    logic [63:0] stats_time;
  } result_t;

  // One ring entry, less its dropped-before flag (kept in its own memory).
  typedef struct packed {
    logic        level;
    logic [31:0] seq_num;
    logic [63:0] stamp;
  } entry_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    return n;
  endfunction

endpackage

// ===== rtl/eetf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module eetf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/edge_event_timestamp_fifo.sv =====
// Timestamped edge event FIFO, overwrite-oldest (top level). Edge, clear and
// empty pop give done in the cycle after the transfer; a queued pop passes through
// the resp state and then the done register. Throughput: one transfer per cycle,
// except that a queued pop holds busy in resp while the ring memories' registered
// read returns. The receiver cannot stall done. Reset (rst, synchronous) clears
// pointers, counters and flags; ring contents are left as they are, since only written entries are ever read.
`include "edge_event_timestamp_fifo_macros.svh"

module edge_event_timestamp_fifo
  import eetf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  // Controller states: idle takes a transfer, resp finishes a ring read.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t            state, state_next;
  logic              pop_lost, pop_lost_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [CNT_W-1:0]  held_count, held_count_next;
  logic              loss_pending, loss_pending_next;
  logic              last_level, last_level_next;
  logic [31:0]       edge_sequence, edge_sequence_next;
  logic [63:0]       last_edge_time, last_edge_time_next;
  logic [63:0]       edges_total, edges_total_next;
  logic [63:0]       events_delivered, events_delivered_next;
  logic [63:0]       events_dropped, events_dropped_next;
  logic [63:0]       stats_edge_time, stats_edge_time_next;
  result_t           result_next;
  logic              done_next;

  // Ring memory ports.
  logic              entry_we;
  entry_t            entry_wdata;
  entry_t            entry_rdata;
  logic              flag_we;
  logic [SLOT_W-1:0] flag_waddr;
  logic [0:0]        flag_wdata;
  logic [0:0]        flag_rdata;

  logic              accept;
  logic              full;
  logic [1:0]        pop_kind;
  logic [31:0]       pop_sequence;
  logic [63:0]       pop_time;
  logic              pop_flag;

  assign busy   = (state == ST_RESP);
  assign accept = start && !busy;
  assign full   = (held_count == CNT_W'(RING_DEPTH));

  // Event payload ring: written on an edge, read at the head slot.
  eetf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (write_slot),
    .wdata (entry_wdata),
    .raddr (read_slot),
    .rdata (entry_rdata)
  );

  // Dropped-before flags live apart so that marking the next head after a lost
  // delivery is a plain write rather than a read-modify-write of the entry.
  eetf_ram #(
    .WIDTH (1),
    .DEPTH (RING_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (read_slot),
    .rdata (flag_rdata)
  );

  always_comb begin
    // Hold everything by default.
    state_next            = state;
    pop_lost_next         = pop_lost;
    write_slot_next       = write_slot;
    read_slot_next        = read_slot;
    held_count_next       = held_count;
    loss_pending_next     = loss_pending;
    last_level_next       = last_level;
    edge_sequence_next    = edge_sequence;
    last_edge_time_next   = last_edge_time;
    edges_total_next      = edges_total;
    events_delivered_next = events_delivered;
    events_dropped_next   = events_dropped;
    stats_edge_time_next  = stats_edge_time;
    done_next             = 1'b0;

    entry_we          = 1'b0;
    entry_wdata.level    = cmd.pin_level;
    entry_wdata.seq_num  = edge_sequence + 32'd1;
    entry_wdata.stamp    = cmd.edge_time;
    flag_we           = 1'b0;
    flag_waddr        = write_slot;
    flag_wdata        = 1'b0;

    pop_kind     = KIND_NONE;
    pop_sequence = '0;
    pop_time     = '0;
    pop_flag     = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            OP_EDGE: begin
              edge_sequence_next   = edge_sequence + 32'd1;
              last_level_next      = cmd.pin_level;
              last_edge_time_next  = cmd.edge_time;
              stats_edge_time_next = cmd.edge_time;
              edges_total_next     = edges_total + 64'd1;
              loss_pending_next    = 1'b0;
              // Flag the new event if anything was lost ahead of it.
              flag_wdata = loss_pending || full;
              entry_we   = 1'b1;
              flag_we    = 1'b1;
              write_slot_next = next_slot(write_slot);
              if (full) begin
                // Ring full: drop the oldest, count stays at depth.
                read_slot_next      = next_slot(read_slot);
                events_dropped_next = events_dropped + 64'd1;
              end else begin
                held_count_next = held_count + 1'b1;
              end
              done_next = 1'b1;
            end
            OP_POP, OP_POP_LOST: begin
              if (held_count != '0) begin
                // Head entry is being read; finish next cycle.
                state_next    = ST_RESP;
                pop_lost_next = (cmd.opcode == OP_POP_LOST);
              end else begin
                done_next = 1'b1;
              end
            end
            OP_CLEAR: begin
              edges_total_next      = '0;
              events_delivered_next = '0;
              events_dropped_next   = '0;
              stats_edge_time_next  = '0;
              done_next             = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        state_next   = ST_IDLE;
        pop_kind     = entry_rdata.level ? KIND_HIGH : KIND_LOW;
        pop_sequence = entry_rdata.seq_num;
        pop_time     = entry_rdata.stamp;
        pop_flag     = flag_rdata[0];
        read_slot_next  = next_slot(read_slot);
        held_count_next = held_count - 1'b1;
        if (pop_lost) begin
          events_dropped_next = events_dropped + 64'd1;
          if (held_count_next != '0) begin
            // Mark the new head so the reader sees the gap.
            flag_we    = 1'b1;
            flag_waddr = read_slot_next;
            flag_wdata = 1'b1;
          end else begin
            loss_pending_next = 1'b1;
          end
        end else begin
          events_delivered_next = events_delivered + 64'd1;
        end
        done_next = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Snapshot of the state after this step.
    result_next.popped_kind           = pop_kind;
    result_next.popped_sequence       = pop_sequence;
    result_next.popped_time           = pop_time;
    result_next.popped_dropped_before = pop_flag;
    result_next.queued_count          = 6'(held_count_next);
    result_next.level_now             = last_level_next;
    result_next.latest_sequence       = edge_sequence_next;
    result_next.latest_time           = last_edge_time_next;
    result_next.total_count           = edges_total_next;
    result_next.delivered_count       = events_delivered_next;
    result_next.dropped_count         = events_dropped_next;
    result_next.stats_time            = stats_edge_time_next;
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pop_lost         <= 1'b0;
      write_slot       <= '0;
      read_slot        <= '0;
      held_count       <= '0;
      loss_pending     <= 1'b0;
      last_level       <= 1'b0;
      edge_sequence    <= '0;
      last_edge_time   <= '0;
      edges_total      <= '0;
      events_delivered <= '0;
      events_dropped   <= '0;
      stats_edge_time  <= '0;
      done             <= 1'b0;
    end else begin
      state            <= state_next;
      pop_lost         <= pop_lost_next;
      write_slot       <= write_slot_next;
      read_slot        <= read_slot_next;
      held_count       <= held_count_next;
      loss_pending     <= loss_pending_next;
      last_level       <= last_level_next;
      edge_sequence    <= edge_sequence_next;
      last_edge_time   <= last_edge_time_next;
      edges_total      <= edges_total_next;
      events_delivered <= events_delivered_next;
      events_dropped   <= events_dropped_next;
      stats_edge_time  <= stats_edge_time_next;
      done             <= done_next;
    end
  end

  // Result payload register, qualified by done.
  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
  end

  `EETF_ASSERT_IMPLY(a_count_bounded, 1'b1, held_count <= CNT_W'(RING_DEPTH))
  `EETF_ASSERT_IMPLY(a_loss_only_when_empty, loss_pending, held_count == '0)
  `EETF_ASSERT_NEXT(a_resp_one_cycle, state == ST_RESP, state == ST_IDLE && done)
  `EETF_ASSERT_IMPLY(a_done_has_cause, done,
                     $past(start && !busy) || $past(state == ST_RESP))
  `EETF_ASSERT_IMPLY(a_empty_pop_zero, done && result.popped_kind == KIND_NONE,
                     result.popped_sequence == '0 && result.popped_time == '0 &&
                     !result.popped_dropped_before)

endmodule

// ===== test/tb_edge_event_timestamp_fifo.sv =====
// Self-checking testbench for edge_event_timestamp_fifo: a directed table, then random
// bursts of edges and pops, each result checked against a cycle-free model of the ring.
// Depends on eetf_pkg (cmd_t, result_t, opcodes, event kinds) and the block's RTL.
module tb_edge_event_timestamp_fifo
  import eetf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;
  // Idle tail after the last awaited result, to catch stray done pulses.
  localparam int DRAIN_CYCLES = 6;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  edge_event_timestamp_fifo dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring model. Mirrors the block's state at transfer granularity: one call per
  // accepted command, returning the single result that command must produce.
  // ---------------------------------------------------------------------------
  bit          ring_level [RING_DEPTH];
  logic [31:0] ring_seq   [RING_DEPTH];
  logic [63:0] ring_stamp [RING_DEPTH];
  bit          ring_flag  [RING_DEPTH];
  int          head_idx;      // oldest queued event
  int          tail_idx;      // next slot to write
  int          fill;
  bit          loss_owed;     // a lost pop left the ring empty; flag the next edge
  bit          cur_level;
  logic [31:0] seq_counter;
  logic [63:0] cur_stamp;
  logic [63:0] n_edges;
  logic [63:0] n_delivered;
  logic [63:0] n_dropped;
  logic [63:0] stat_stamp;

  // Coverage tallies for the closing summary.
  int overwrites;
  int empty_pops;
  int flagged_pops;
  int lost_pops;

  function automatic result_t ring_advance(cmd_t c);
    result_t r;
    bit      mark;
    r    = '0;
    mark = 1'b0;
    case (opcode_t'(c.opcode))
      OP_EDGE: begin
        seq_counter = seq_counter + 32'd1;
        cur_level   = c.pin_level;
        cur_stamp   = c.edge_time;
        stat_stamp  = c.edge_time;
        n_edges     = n_edges + 64'd1;
        if (loss_owed) begin
          mark      = 1'b1;
          loss_owed = 1'b0;
        end
        // Full ring: drop the oldest to make room, and flag the newcomer.
        if (fill == RING_DEPTH) begin
          head_idx  = (head_idx + 1) % RING_DEPTH;
          fill      = fill - 1;
          n_dropped = n_dropped + 64'd1;
          mark      = 1'b1;
          overwrites++;
        end
        ring_level[tail_idx] = c.pin_level;
        ring_seq[tail_idx]   = seq_counter;
        ring_stamp[tail_idx] = c.edge_time;
        ring_flag[tail_idx]  = mark;
        tail_idx = (tail_idx + 1) % RING_DEPTH;
        fill     = fill + 1;
      end
      OP_POP, OP_POP_LOST: begin
        if (fill == 0) begin
          empty_pops++;
        end else begin
          r.popped_kind           = ring_level[head_idx] ? KIND_HIGH : KIND_LOW;
          r.popped_sequence       = ring_seq[head_idx];
          r.popped_time           = ring_stamp[head_idx];
          r.popped_dropped_before = ring_flag[head_idx];
          if (ring_flag[head_idx]) flagged_pops++;
          head_idx = (head_idx + 1) % RING_DEPTH;
          fill     = fill - 1;
          if (opcode_t'(c.opcode) == OP_POP) begin
            n_delivered = n_delivered + 64'd1;
          end else begin
            // Lost in delivery: count it and warn whoever reads next.
            lost_pops++;
            n_dropped = n_dropped + 64'd1;
            if (fill != 0) ring_flag[head_idx] = 1'b1;
            else loss_owed = 1'b1;
          end
        end
      end
      default: begin
        n_edges     = '0;
        n_delivered = '0;
        n_dropped   = '0;
        stat_stamp  = '0;
      end
    endcase
    r.queued_count    = 6'(fill);
    r.level_now       = cur_level;
    r.latest_sequence = seq_counter;
    r.latest_time     = cur_stamp;
    r.total_count     = n_edges;
    r.delivered_count = n_delivered;
    r.dropped_count   = n_dropped;
    r.stats_time      = stat_stamp;
    return r;
  endfunction

  initial begin
    head_idx     = 0;
    tail_idx     = 0;
    fill         = 0;
    loss_owed    = 1'b0;
    cur_level    = 1'b0;
    seq_counter  = '0;
    cur_stamp    = '0;
    n_edges      = '0;
    n_delivered  = '0;
    n_dropped    = '0;
    stat_stamp   = '0;
    overwrites   = 0;
    empty_pops   = 0;
    flagged_pops = 0;
    lost_pops    = 0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, before the block's own
  // nonblocking updates land, so the order of processes within the step is moot.
  // ---------------------------------------------------------------------------
  result_t awaited_results[$];
  int      fail_count;
  int      results_seen;
  bit      use_typed;       // current command carries a hand-written expectation
  result_t typed_result;

  initial begin
    fail_count   = 0;
    results_seen = 0;
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t modelled;
    if (!rst) begin
      // Retire the oldest expectation against whatever done presents.
      if (done === 1'b1) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, result);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("popped_kind", want.popped_kind, result.popped_kind);
          check_field("popped_sequence", want.popped_sequence, result.popped_sequence);
          check_field("popped_time", want.popped_time, result.popped_time);
          check_field("popped_dropped_before", want.popped_dropped_before,
                      result.popped_dropped_before);
          check_field("queued_count", want.queued_count, result.queued_count);
          check_field("level_now", want.level_now, result.level_now);
          check_field("latest_sequence", want.latest_sequence, result.latest_sequence);
          check_field("latest_time", want.latest_time, result.latest_time);
          check_field("total_count", want.total_count, result.total_count);
          check_field("delivered_count", want.delivered_count, result.delivered_count);
          check_field("dropped_count", want.dropped_count, result.dropped_count);
          check_field("stats_time", want.stats_time, result.stats_time);
        end
      end
      // Accepted transfer: advance the model and queue what must come back.
      // Rows with a typed expectation still advance the model to keep it in step.
      if (start === 1'b1 && busy === 1'b0) begin
        modelled = ring_advance(cmd);
        awaited_results.push_back(use_typed ? typed_result : modelled);
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  int cycle_count;
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_results.size());
      $display("edge_event_timestamp_fifo verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } plan_row_t;

  plan_row_t plan[$];
  int        transfers_sent;
  int        random_sent;

  function automatic cmd_t mk(opcode_t op, bit lvl, logic [63:0] stamp);
    cmd_t c;
    c.opcode    = op;
    c.pin_level = lvl;
    c.edge_time = stamp;
    return c;
  endfunction

  task automatic add_row(input cmd_t c, input bit typed, input result_t want);
    plan_row_t row;
    row.c     = c;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  // Random level and stamp, with the occasional extreme stamp. Fields that a pop
  // or a clear ignores are randomised too, so the block must truly ignore them.
  function automatic cmd_t rand_cmd(opcode_t op);
    logic [63:0] stamp;
    case ($urandom_range(15))
      0:       stamp = '0;
      1:       stamp = '1;
      default: stamp = {$urandom, $urandom};
    endcase
    return mk(op, 1'($urandom_range(1)), stamp);
  endfunction

  // Offer one command and hold it until the block takes it. The sender may idle
  // first; start is only lowered when it does, so a back-to-back stream keeps
  // start high with a single assignment per step.
  task automatic offer(input cmd_t c, input bit typed, input result_t want,
                       input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    use_typed    <= typed;
    typed_result <= want;
    do @(posedge clk); while (busy !== 1'b0);
    transfers_sent++;
  endtask

  initial begin : driver
    result_t none;
    int      mode;
    int      burst;
    int      idle_pct;
    int      pick;
    opcode_t op;
    none           = '0;
    transfers_sent = 0;
    random_sent    = 0;
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    use_typed      = 1'b0;
    typed_result   = '0;

    // Directed table. Early rows start from reset, so their results are typed in;
    // later ones depend on loss bookkeeping and go to the model.
    add_row(mk(OP_POP, 1'b0, '0), 1'b1, '0);                      // pop, empty ring
    add_row(mk(OP_POP_LOST, 1'b1, '1), 1'b1, '0);                 // lost pop, empty ring
    add_row(mk(OP_CLEAR, 1'b1, '1), 1'b1, '0);                    // clear at reset state
    add_row(mk(OP_EDGE, 1'b1, '1), 1'b1,
            result_t'{queued_count: 6'd1, level_now: 1'b1, latest_sequence: 32'd1,
                      latest_time: '1, total_count: 64'd1, stats_time: '1, default: '0});
    add_row(mk(OP_EDGE, 1'b0, '0), 1'b1,
            result_t'{queued_count: 6'd2, latest_sequence: 32'd2, total_count: 64'd2,
                      default: '0});
    add_row(mk(OP_POP, 1'b1, '1), 1'b1,
            result_t'{popped_kind: KIND_HIGH, popped_sequence: 32'd1, popped_time: '1,
                      queued_count: 6'd1, latest_sequence: 32'd2, total_count: 64'd2,
                      delivered_count: 64'd1, default: '0});
    add_row(mk(OP_POP_LOST, 1'b0, '0), 1'b1,
            result_t'{popped_kind: KIND_LOW, popped_sequence: 32'd2,
                      latest_sequence: 32'd2, total_count: 64'd2, delivered_count: 64'd1,
                      dropped_count: 64'd1, default: '0});
    add_row(mk(OP_POP, 1'b1, '1), 1'b1,                           // empty, loss owed
            result_t'{latest_sequence: 32'd2, total_count: 64'd2, delivered_count: 64'd1,
                      dropped_count: 64'd1, default: '0});
    add_row(mk(OP_EDGE, 1'b1, 64'h5555_5555_5555_5555), 1'b0, none); // takes owed flag
    add_row(mk(OP_EDGE, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA), 1'b0, none);
    add_row(mk(OP_EDGE, 1'b1, 64'h8000_0000_0000_0000), 1'b0, none);
    add_row(mk(OP_POP, 1'b0, '0), 1'b0, none);                    // flagged event out
    add_row(mk(OP_POP_LOST, 1'b1, 64'h1), 1'b0, none);            // flags the next one
    add_row(mk(OP_CLEAR, 1'b0, 64'h0123_4567_89AB_CDEF), 1'b0, none); // ring kept
    add_row(mk(OP_POP, 1'b1, '1), 1'b0, none);
    add_row(mk(OP_EDGE, 1'b0, 64'h0000_0000_0000_0001), 1'b0, none);
    add_row(mk(OP_POP_LOST, 1'b0, '0), 1'b0, none);               // last one lost
    add_row(mk(OP_EDGE, 1'b1, 64'hFFFF_FFFF_0000_0000), 1'b0, none);
    add_row(mk(OP_POP, 1'b0, '0), 1'b0, none);
    add_row(mk(OP_POP_LOST, 1'b1, '1), 1'b0, none);               // empty again

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i].c, plan[i].typed, plan[i].want, 0);

    // Random bursts. Thirds of the run: no sender gaps, heavy gaps, light gaps.
    // Long edge bursts fill and overrun the ring; drains empty it again, with
    // lost pops mixed in so loss flags land on queued and on future events.
    while (random_sent < RANDOM_ITEMS) begin
      case (random_sent * 3 / RANDOM_ITEMS)
        0:       idle_pct = 0;
        1:       idle_pct = 54;
        default: idle_pct = 9;
      endcase
      mode = $urandom_range(99);
      if (mode < 25)      burst = $urandom_range(40, 30);
      else if (mode < 55) burst = $urandom_range(8, 1);
      else if (mode < 80) burst = $urandom_range(35, 1);
      else                burst = $urandom_range(6, 2);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (mode < 25) begin
          op = OP_EDGE;
        end else if (mode < 55) begin
          op = (pick < 45) ? OP_EDGE : (pick < 75) ? OP_POP :
               (pick < 95) ? OP_POP_LOST : OP_CLEAR;
        end else if (mode < 80) begin
          op = (pick < 30) ? OP_POP_LOST : OP_POP;
        end else begin
          op = opcode_t'($urandom_range(3));
        end
        offer(rand_cmd(op), 1'b0, none, idle_pct);
        random_sent++;
      end
    end
    start <= 1'b0;

    // Drain: wait for every queued expectation, then a short tail to catch strays.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers (%0d random), %0d results checked.",
             transfers_sent, random_sent, results_seen);
    $display("Ring overruns %0d, empty pops %0d, lost pops %0d, flagged events popped %0d.",
             overwrites, empty_pops, lost_pops, flagged_pops);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("edge_event_timestamp_fifo verification clean");
    end else begin
      $display("edge_event_timestamp_fifo verification failed");
    end
    $finish;
  end

endmodule

// ===== edge_event_timestamp_fifo.f =====
+incdir+rtl
rtl/eetf_pkg.sv
rtl/eetf_ram.sv
rtl/edge_event_timestamp_fifo.sv
test/tb_edge_event_timestamp_fifo.sv
